// ----- src/imhpq_pkg.sv -----
// Shared types and constants of the indexed min-heap priority queue.
package imhpq_pkg;

	// Fixed field widths of the stream beats.
	localparam int ModeBits    = 2;
	localparam int HdlBits     = 10;
	localparam int KeyInBits   = 32;
	localparam int StatusBits  = 3;
	localparam int CountBits   = 11;
	localparam int InDataBits  = 48;
	localparam int OutDataBits = 56;

	typedef enum logic [ModeBits-1:0] {
		MD_INSERT  = 2'd0,
		MD_EXTRACT = 2'd1,
		MD_SETKEY  = 2'd2,
		MD_DELETE  = 2'd3
	} mode_t;

	typedef enum logic [StatusBits-1:0] {
		ST_OK      = 3'd0,
		ST_EMPTY   = 3'd1,
		ST_FULL    = 3'd2,
		ST_ABSENT  = 3'd3,
		ST_PRESENT = 3'd4
	} status_t;

	// Datapath operations issued by the controller, one per cycle.
	typedef enum logic [4:0] {
		DP_NOP,
		DP_CLEAR,
		DP_LOAD,
		DP_INS,
		DP_SETKEY,
		DP_DEL_SLOT,
		DP_DEL_ROOT,
		DP_ORIG,
		DP_PUP_WR,
		DP_REMOVE,
		DP_LAST,
		DP_DN_RDL,
		DP_DN_L,
		DP_DN_R,
		DP_UP_RD,
		DP_UP_CMP,
		DP_PLACE,
		DP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t status;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic in_range;
		logic present;
		logic full;
		logic empty;
		logic i_zero;
		logic p_zero;
		logic count_one;
		logic l_in;
		logic up_move;
		logic dn_stop;
		logic out_busy;
	} dp_stat_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_ORIG,
		S_PUP,
		S_REMOVE,
		S_LAST,
		S_DN_RDL,
		S_DN_L,
		S_DN_R,
		S_UP_RD,
		S_UP_CMP,
		S_PLACE,
		S_FINISH
	} state_t;

endpackage

// ----- src/imhpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module imhpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/imhpq_ctrl.sv -----
// Controller state machine that sequences lookups, sifts and result beats.
module imhpq_ctrl import imhpq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic [ModeBits-1:0] s_mode,
	output logic                s_tready,
	output dp_cmd_t             cmd,
	input  dp_stat_t            st
);

	state_t  state_q, state_d;
	mode_t   mode_q;
	status_t status_q, status_d;

	// State, mode and result status registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			mode_q   <= MD_INSERT;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (state_q == S_IDLE && s_tvalid) begin
				mode_q <= mode_t'(s_mode);
			end
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d    = state_q;
		status_d   = status_q;
		s_tready   = 1'b0;
		cmd.op     = DP_NOP;
		cmd.status = ST_OK;
		case (state_q)
			S_CLEAR: begin
				cmd.op = DP_CLEAR;
				if (st.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op   = DP_LOAD;
					status_d = ST_OK;
					state_d  = S_LOOK;
				end
			end
			S_LOOK: begin
				case (mode_q)
					MD_INSERT: begin
						if (!st.in_range) begin
							status_d = ST_ABSENT;
							state_d  = S_FINISH;
						end else if (st.present) begin
							status_d = ST_PRESENT;
							state_d  = S_FINISH;
						end else if (st.full) begin
							status_d = ST_FULL;
							state_d  = S_FINISH;
						end else begin
							cmd.op  = DP_INS;
							state_d = S_UP_RD;
						end
					end
					MD_EXTRACT: begin
						if (st.empty) begin
							status_d = ST_EMPTY;
							state_d  = S_FINISH;
						end else begin
							cmd.op  = DP_DEL_ROOT;
							state_d = S_ORIG;
						end
					end
					MD_SETKEY: begin
						if (!st.in_range || !st.present) begin
							status_d = ST_ABSENT;
							state_d  = S_FINISH;
						end else begin
							cmd.op  = DP_SETKEY;
							state_d = S_UP_RD;
						end
					end
					default: begin
						if (!st.in_range || !st.present) begin
							status_d = ST_ABSENT;
							state_d  = S_FINISH;
						end else begin
							cmd.op  = DP_DEL_SLOT;
							state_d = S_ORIG;
						end
					end
				endcase
			end
			S_ORIG: begin
				cmd.op  = DP_ORIG;
				state_d = st.i_zero ? S_REMOVE : S_PUP;
			end
			S_PUP: begin
				cmd.op  = DP_PUP_WR;
				state_d = st.p_zero ? S_REMOVE : S_PUP;
			end
			S_REMOVE: begin
				cmd.op  = DP_REMOVE;
				state_d = st.count_one ? S_FINISH : S_LAST;
			end
			S_LAST: begin
				cmd.op  = DP_LAST;
				state_d = S_DN_RDL;
			end
			S_DN_RDL: begin
				if (st.l_in) begin
					cmd.op  = DP_DN_RDL;
					state_d = S_DN_L;
				end else begin
					cmd.op  = DP_PLACE;
					state_d = S_FINISH;
				end
			end
			S_DN_L: begin
				cmd.op  = DP_DN_L;
				state_d = S_DN_R;
			end
			S_DN_R: begin
				cmd.op  = DP_DN_R;
				state_d = st.dn_stop ? S_FINISH : S_DN_RDL;
			end
			S_UP_RD: begin
				if (st.i_zero) begin
					cmd.op  = DP_PLACE;
					state_d = S_FINISH;
				end else begin
					cmd.op  = DP_UP_RD;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				cmd.op = DP_UP_CMP;
				if (!st.up_move) begin
					state_d = S_FINISH;
				end else if (st.p_zero) begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				cmd.op  = DP_PLACE;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!st.out_busy) begin
					cmd.op     = DP_EMIT;
					cmd.status = status_q;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- src/imhpq_dp.sv -----
// Datapath: heap and position memories, index arithmetic and result register.
module imhpq_dp import imhpq_pkg::*; #(
	parameter int CAPACITY     = 1024,
	parameter int HANDLE_COUNT = 1024,
	parameter int KEY_BITS     = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dp_cmd_t                     cmd,
	output dp_stat_t                    st,
	input  logic [HdlBits-1:0]          s_handle,
	input  logic signed [KeyInBits-1:0] s_key,
	output logic                        m_valid,
	input  logic                        m_ready,
	output status_t                     m_status,
	output logic [HdlBits-1:0]          m_handle,
	output logic [KeyInBits-1:0]        m_key,
	output logic [CountBits-1:0]        m_count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int HW = $clog2(HANDLE_COUNT);
	localparam int EW = KEY_BITS + HW;
	localparam int SW = AW + 1;

	// Heap memory holds {key, handle}; position memory holds {present, slot}.
	logic          heap_we;
	logic [AW-1:0] heap_waddr, heap_raddr;
	logic [EW-1:0] heap_wdata, heap_rdata;
	logic          slot_we;
	logic [HW-1:0] slot_waddr, slot_raddr;
	logic [SW-1:0] slot_wdata, slot_rdata;

	imhpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap_ram (
		.clk   (clk),
		.we    (heap_we),
		.waddr (heap_waddr),
		.wdata (heap_wdata),
		.raddr (heap_raddr),
		.rdata (heap_rdata)
	);

	imhpq_ram #(.WIDTH(SW), .DEPTH(HANDLE_COUNT)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	// Control registers.
	logic [CW-1:0] count_q;
	logic [HW-1:0] clr_q;
	logic          m_valid_q;

	// Working registers.
	logic [HdlBits-1:0]         h_q;
	logic signed [KEY_BITS-1:0] key_q;
	logic signed [KEY_BITS-1:0] e_key_q;
	logic [HW-1:0]              e_hdl_q;
	logic [AW-1:0]              i_q;
	logic signed [KEY_BITS-1:0] cand_key_q;
	logic [HW-1:0]              cand_hdl_q;
	logic [AW-1:0]              cand_idx_q;
	logic                       cand_self_q;
	logic signed [KEY_BITS-1:0] res_key_q;
	logic [HW-1:0]              res_hdl_q;
	status_t                    m_status_q;
	logic [HdlBits-1:0]         m_handle_q;
	logic [KeyInBits-1:0]       m_key_q;
	logic [CountBits-1:0]       m_count_q;

	// Field views of the memory read data.
	logic signed [KEY_BITS-1:0] rd_key;
	logic [HW-1:0]              rd_hdl;
	logic                       sl_present;
	logic [AW-1:0]              sl_idx;

	assign rd_key     = signed'(heap_rdata[EW-1:HW]);
	assign rd_hdl     = heap_rdata[HW-1:0];
	assign sl_present = slot_rdata[AW];
	assign sl_idx     = slot_rdata[AW-1:0];

	// Tree index arithmetic around the current slot.
	logic [AW-1:0] parent_idx, gparent_idx, l_idx, r_idx;
	logic [AW+1:0] l_ext, r_ext, count_ext;
	logic          l_in, r_in, up_move, l_less, take_r, dn_stop;

	assign parent_idx  = (i_q - 1'b1) >> 1;
	assign gparent_idx = (parent_idx - 1'b1) >> 1;
	assign l_ext       = {1'b0, i_q, 1'b1};
	assign r_ext       = l_ext + 1'b1;
	assign count_ext   = (AW + 2)'(count_q);
	assign l_in        = l_ext < count_ext;
	assign r_in        = r_ext < count_ext;
	assign l_idx       = l_ext[AW-1:0];
	assign r_idx       = r_ext[AW-1:0];
	assign up_move     = e_key_q < rd_key;
	assign l_less      = rd_key < e_key_q;
	assign take_r      = r_in && (rd_key < cand_key_q);
	assign dn_stop     = !take_r && cand_self_q;

	// Status flags back to the controller.
	always_comb begin
		st.clr_done  = clr_q == HW'(HANDLE_COUNT - 1);
		st.in_range  = 32'(h_q) < HANDLE_COUNT;
		st.present   = sl_present;
		st.full      = count_q == CW'(CAPACITY);
		st.empty     = count_q == '0;
		st.i_zero    = i_q == '0;
		st.p_zero    = parent_idx == '0;
		st.count_one = count_q == CW'(1);
		st.l_in      = l_in;
		st.up_move   = up_move;
		st.dn_stop   = dn_stop;
		st.out_busy  = m_valid_q && !m_ready;
	end

	// Memory port control per operation.
	always_comb begin
		heap_we    = 1'b0;
		heap_waddr = i_q;
		heap_wdata = {e_key_q, e_hdl_q};
		heap_raddr = '0;
		slot_we    = 1'b0;
		slot_waddr = e_hdl_q;
		slot_wdata = {1'b1, i_q};
		slot_raddr = '0;
		case (cmd.op)
			DP_CLEAR: begin
				slot_we    = 1'b1;
				slot_waddr = clr_q;
				slot_wdata = '0;
			end
			DP_LOAD: begin
				slot_raddr = HW'(s_handle);
			end
			DP_DEL_SLOT: begin
				heap_raddr = sl_idx;
			end
			DP_ORIG: begin
				heap_raddr = parent_idx;
			end
			DP_PUP_WR: begin
				heap_we    = 1'b1;
				heap_wdata = heap_rdata;
				slot_we    = 1'b1;
				slot_waddr = rd_hdl;
				heap_raddr = gparent_idx;
			end
			DP_REMOVE: begin
				slot_we    = 1'b1;
				slot_waddr = res_hdl_q;
				slot_wdata = '0;
				heap_raddr = AW'(count_q - 1'b1);
			end
			DP_DN_RDL: begin
				heap_raddr = l_idx;
			end
			DP_DN_L: begin
				heap_raddr = r_idx;
			end
			DP_DN_R: begin
				heap_we = 1'b1;
				slot_we = 1'b1;
				if (take_r) begin
					heap_wdata = heap_rdata;
					slot_waddr = rd_hdl;
				end else begin
					heap_wdata = {cand_key_q, cand_hdl_q};
					slot_waddr = cand_hdl_q;
				end
			end
			DP_UP_RD: begin
				heap_raddr = parent_idx;
			end
			DP_UP_CMP: begin
				heap_we = 1'b1;
				slot_we = 1'b1;
				if (up_move) begin
					heap_wdata = heap_rdata;
					slot_waddr = rd_hdl;
					heap_raddr = gparent_idx;
				end
			end
			DP_PLACE: begin
				heap_we = 1'b1;
				slot_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Control state with reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			clr_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cmd.op == DP_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.op == DP_INS) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.op == DP_REMOVE) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.op == DP_EMIT) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Working and result registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				h_q       <= s_handle;
				key_q     <= KEY_BITS'(s_key);
				res_key_q <= '0;
				res_hdl_q <= '0;
			end
			DP_INS: begin
				e_key_q <= key_q;
				e_hdl_q <= HW'(h_q);
				i_q     <= AW'(count_q);
			end
			DP_SETKEY: begin
				e_key_q <= key_q;
				e_hdl_q <= HW'(h_q);
				i_q     <= sl_idx;
			end
			DP_DEL_SLOT: begin
				i_q <= sl_idx;
			end
			DP_DEL_ROOT: begin
				i_q <= '0;
			end
			DP_ORIG: begin
				res_key_q <= rd_key;
				res_hdl_q <= rd_hdl;
			end
			DP_PUP_WR: begin
				i_q <= parent_idx;
			end
			DP_LAST: begin
				e_key_q <= rd_key;
				e_hdl_q <= rd_hdl;
				i_q     <= '0;
			end
			DP_DN_L: begin
				if (l_less) begin
					cand_key_q  <= rd_key;
					cand_hdl_q  <= rd_hdl;
					cand_idx_q  <= l_idx;
					cand_self_q <= 1'b0;
				end else begin
					cand_key_q  <= e_key_q;
					cand_hdl_q  <= e_hdl_q;
					cand_idx_q  <= i_q;
					cand_self_q <= 1'b1;
				end
			end
			DP_DN_R: begin
				if (!dn_stop) begin
					i_q <= take_r ? r_idx : cand_idx_q;
				end
			end
			DP_UP_CMP: begin
				if (up_move) begin
					i_q <= parent_idx;
				end
			end
			DP_EMIT: begin
				m_status_q <= cmd.status;
				m_handle_q <= HdlBits'(res_hdl_q);
				m_key_q    <= KeyInBits'(res_key_q);
				m_count_q  <= CountBits'(count_q);
			end
			default: begin
			end
		endcase
	end

	assign m_valid  = m_valid_q;
	assign m_status = m_status_q;
	assign m_handle = m_handle_q;
	assign m_key    = m_key_q;
	assign m_count  = m_count_q;

endmodule

// ----- src/indexed_min_heap_priority_queue.sv -----
// Top level of the indexed binary min-heap priority queue.
//
// Binary min-heap of (key, handle) entries with a per-handle position table, so that a held
// handle can be rekeyed or deleted. Beats are processed one at a time. After reset a clearing
// pass walks the position memory; no beat is taken until it ends. Every step of a sift is
// bound by the single read port of the heap memory. Insert and set-key read the parent, then
// compare and move up one level per step. Extract reads the left child, then the right child,
// then moves the smallest of the three up, for each level descended. Delete first carries its
// entry up to the root, one level per step. A failed request (empty, full, handle absent or
// present) goes from the lookup straight to the result. The result register lets a new beat
// be accepted while the previous result waits.
module indexed_min_heap_priority_queue import imhpq_pkg::*; #(
	parameter int CAPACITY     = 1024,
	parameter int HANDLE_COUNT = 1024,
	parameter int KEY_BITS     = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [InDataBits-1:0]  s_tdata,  // handle[9:0], key[41:10], zero fill
	input  logic [ModeBits-1:0]    s_tuser,  // mode[1:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OutDataBits-1:0] m_tdata,  // out_handle[9:0], out_key[41:10], count[52:42]
	output logic [StatusBits-1:0]  m_tuser   // status[2:0]
);

	dp_cmd_t  cmd;
	dp_stat_t st;
	status_t  m_status;
	logic [HdlBits-1:0]   m_handle;
	logic [KeyInBits-1:0] m_key;
	logic [CountBits-1:0] m_count;

	imhpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_mode   (s_tuser),
		.s_tready (s_tready),
		.cmd      (cmd),
		.st       (st)
	);

	imhpq_dp #(
		.CAPACITY     (CAPACITY),
		.HANDLE_COUNT (HANDLE_COUNT),
		.KEY_BITS     (KEY_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.s_handle (s_tdata[HdlBits-1:0]),
		.s_key    (signed'(s_tdata[HdlBits+KeyInBits-1:HdlBits])),
		.m_valid  (m_tvalid),
		.m_ready  (m_tready),
		.m_status (m_status),
		.m_handle (m_handle),
		.m_key    (m_key),
		.m_count  (m_count)
	);

	// Pack the result beat.
	assign m_tdata = {
		(OutDataBits - HdlBits - KeyInBits - CountBits)'(0), m_count, m_key, m_handle
	};
	assign m_tuser = m_status;

	// A beat is taken only from the idle state, so ready drops right after an accept.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
	else $error("input taken while a request is in progress");

	// A failed request removes nothing.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |-> m_tdata[HdlBits+KeyInBits-1:0] == '0)
	else $error("failed request reports a removed entry");

	// An empty report means the heap holds nothing.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_EMPTY) |->
		m_tdata[HdlBits+KeyInBits+CountBits-1:HdlBits+KeyInBits] == '0)
	else $error("empty status with a nonzero count");

endmodule

// ----- verif/imhpq_checker.sv -----
// Checker for the indexed min-heap priority queue: predicts each result beat and compares it.
module imhpq_checker import imhpq_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [InDataBits-1:0]  s_tdata,
	input  logic [ModeBits-1:0]    s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OutDataBits-1:0] m_tdata,
	input  logic [StatusBits-1:0]  m_tuser,
	output int                     fail_count,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Cap = 1024;

	typedef struct packed {
		status_t     status;
		logic [9:0]  hdl;
		logic [31:0] key;
		logic [10:0] count;
	} heap_result_t;

	// Shadow copy of the heap.
	logic signed [31:0] shadow_key[Cap];
	logic [9:0]         shadow_hdl[Cap];
	logic [9:0]         slot_of[Cap];
	bit                 held_flag[Cap];
	int                 held_count;
	heap_result_t       awaited[$];

	function automatic void swap_entries(int a, int b);
		logic signed [31:0] k;
		logic [9:0] h;
		k = shadow_key[a]; h = shadow_hdl[a];
		shadow_key[a] = shadow_key[b]; shadow_hdl[a] = shadow_hdl[b];
		shadow_key[b] = k; shadow_hdl[b] = h;
		slot_of[shadow_hdl[a]] = a[9:0];
		slot_of[shadow_hdl[b]] = b[9:0];
	endfunction

	function automatic void climb(int i);
		int p;
		while (i != 0) begin
			p = (i - 1) / 2;
			if (!(shadow_key[i] < shadow_key[p]))
				break;
			swap_entries(i, p);
			i = p;
		end
	endfunction

	function automatic void take_root(output logic [9:0] h, output logic [31:0] k);
		int i, l, r, s;
		h = shadow_hdl[0];
		k = shadow_key[0];
		held_flag[h] = 0;
		held_count--;
		if (held_count > 0) begin
			shadow_key[0] = shadow_key[held_count];
			shadow_hdl[0] = shadow_hdl[held_count];
			slot_of[shadow_hdl[0]] = 0;
			i = 0;
			forever begin
				l = 2 * i + 1; r = 2 * i + 2; s = i;
				if (l < held_count && shadow_key[l] < shadow_key[s]) s = l;
				if (r < held_count && shadow_key[r] < shadow_key[s]) s = r;
				if (s == i) break;
				swap_entries(i, s);
				i = s;
			end
		end
	endfunction

	function automatic heap_result_t apply_request(mode_t md, logic [9:0] h,
			logic signed [31:0] k);
		heap_result_t res;
		int i;
		logic [31:0] orig;
		res = '0;
		res.status = ST_OK;
		case (md)
			MD_INSERT: begin
				if (held_flag[h]) res.status = ST_PRESENT;
				else if (held_count >= Cap) res.status = ST_FULL;
				else begin
					i = held_count++;
					shadow_key[i] = k; shadow_hdl[i] = h;
					slot_of[h] = i[9:0]; held_flag[h] = 1;
					climb(i);
				end
			end
			MD_EXTRACT: begin
				if (held_count == 0) res.status = ST_EMPTY;
				else take_root(res.hdl, res.key);
			end
			MD_SETKEY: begin
				if (!held_flag[h]) res.status = ST_ABSENT;
				else begin
					shadow_key[slot_of[h]] = k;
					climb(slot_of[h]);
				end
			end
			default: begin
				if (!held_flag[h]) res.status = ST_ABSENT;
				else begin
					i = slot_of[h];
					orig = shadow_key[i];
					while (i != 0) begin
						swap_entries(i, (i - 1) / 2);
						i = (i - 1) / 2;
					end
					take_root(res.hdl, res.key);
					res.key = orig;
				end
			end
		endcase
		res.count = held_count[10:0];
		return res;
	endfunction

	// Predict on accepted requests, compare on accepted results.
	always @(posedge clk or negedge arst_n) begin
		heap_result_t seen, want;
		if (!arst_n) begin
			held_count = 0;
			for (int j = 0; j < Cap; j++) held_flag[j] = 0;
			awaited.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (s_tvalid && s_tready)
				awaited.push_back(apply_request(mode_t'(s_tuser), s_tdata[9:0],
					s_tdata[41:10]));
			if (m_tvalid && m_tready) begin
				seen.status = status_t'(m_tuser);
				seen.hdl = m_tdata[9:0];
				seen.key = m_tdata[41:10];
				seen.count = m_tdata[52:42];
				if (awaited.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("Unexpected result beat: %p", seen);
				end else begin
					want = awaited.pop_front();
					if (seen !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("Result differs: expected %p, got %p", want, seen);
					end
				end
			end
			pending = awaited.size();
		end
	end
endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the indexed min-heap priority queue: stimulus, reset and verdict.
module tb_top import imhpq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [InDataBits-1:0]  s_tdata;
	logic [ModeBits-1:0]    s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OutDataBits-1:0] m_tdata;
	logic [StatusBits-1:0]  m_tuser;
	int                     fail_count;
	int                     pending;
	int                     send_idle_pct;
	int                     recv_idle_pct;
	int                     quiet_cycles = 0;
	logic [9:0]             live_hdls[$];

	indexed_min_heap_priority_queue dut (.*);

	imhpq_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Receiver stalls at random.
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle_pct);

	// Watchdog on cycles with no beat on either side; the reset clearing pass is covered.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Send one request beat, with a random idle gap first; valid stays up until the next call.
	task automatic send_beat(mode_t md, logic [9:0] h, logic [31:0] k);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= md;
		s_tdata <= {6'd0, k, h};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Random key: sometimes small to provoke ties, sometimes extreme, otherwise fully random.
	function automatic logic [31:0] pick_key();
		case ($urandom_range(3))
			0: return $urandom_range(7);
			1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Handles come from a small pool, so rekeys and deletes usually hit held entries.
	task automatic random_beats(int n);
		logic [9:0] h;
		int sel;
		for (int j = 0; j < n; j++) begin
			sel = $urandom_range(99);
			h = (live_hdls.size() > 0 && $urandom_range(3) != 0)
				? live_hdls[$urandom_range(live_hdls.size() - 1)]
				: ($urandom_range(4) == 0 ? 10'($urandom) : 10'($urandom_range(63)));
			if (sel < 40) begin
				send_beat(MD_INSERT, h, pick_key());
				live_hdls.push_back(h);
				if (live_hdls.size() > 200) void'(live_hdls.pop_front());
			end else if (sel < 65) send_beat(MD_EXTRACT, 10'($urandom), $urandom);
			else if (sel < 82) send_beat(MD_SETKEY, h, pick_key());
			else send_beat(MD_DELETE, h, $urandom);
		end
	endtask

	initial begin
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = MD_INSERT;
		send_idle_pct = 33;
		recv_idle_pct = 77;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: empty extract, absent handles, extremes, ties, rekey up and down, delete.
		send_beat(MD_EXTRACT, 10'd0, 32'd0);
		send_beat(MD_SETKEY, 10'd5, 32'd1);
		send_beat(MD_DELETE, 10'h3ff, 32'd0);
		send_beat(MD_INSERT, 10'h3ff, 32'h7fff_ffff);
		send_beat(MD_INSERT, 10'd0, 32'h8000_0000);
		send_beat(MD_INSERT, 10'd0, 32'd3);
		send_beat(MD_INSERT, 10'h2aa, 32'h0001_0000);
		send_beat(MD_INSERT, 10'h155, 32'h0001_0000);
		send_beat(MD_INSERT, 10'd7, 32'hffff_ffff);
		send_beat(MD_SETKEY, 10'h3ff, 32'h8000_0001);
		send_beat(MD_SETKEY, 10'd0, 32'h7fff_fffe);
		send_beat(MD_DELETE, 10'h155, 32'h5555_5555);
		send_beat(MD_DELETE, 10'h155, 32'haaaa_aaaa);
		send_beat(MD_EXTRACT, 10'd0, 32'd0);
		send_beat(MD_EXTRACT, 10'd0, 32'd0);
		send_beat(MD_EXTRACT, 10'd0, 32'd0);
		send_beat(MD_EXTRACT, 10'd0, 32'd0);
		send_beat(MD_EXTRACT, 10'd0, 32'd0);

		random_beats(70);
		send_idle_pct = 77; recv_idle_pct = 33;
		random_beats(70);

		// Fill to capacity, try one more, then rekey and drain a part.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int j = 0; j < 1024; j++) send_beat(MD_INSERT, 10'(j), $urandom);
		send_beat(MD_INSERT, 10'd1, 32'd0);
		send_beat(MD_SETKEY, 10'd1023, 32'h8000_0000);
		send_beat(MD_DELETE, 10'd512, 32'd0);
		send_beat(MD_INSERT, 10'd512, 32'd9);
		send_beat(MD_INSERT, 10'd600, 32'd9);
		for (int j = 0; j < 100; j++) send_beat(MD_EXTRACT, 10'd0, 32'd0);

		// Hold off until every result has been delivered.
		s_tvalid <= 0;
		while (pending != 0) @(negedge clk);
		@(negedge clk);

		random_beats(70);

		s_tvalid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ----- filelist.f -----
src/imhpq_pkg.sv
src/imhpq_ram.sv
src/imhpq_ctrl.sv
src/imhpq_dp.sv
src/indexed_min_heap_priority_queue.sv
verif/imhpq_checker.sv
verif/tb_top.sv
